// File: src/intel_hex_stream_parser_top_macros.svh
// Assertion macros for the checker file of the HEX record parser.
`ifndef INTEL_HEX_STREAM_PARSER_TOP_MACROS_SVH
`define INTEL_HEX_STREAM_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IHSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IHSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/ihsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HEX record parser package
// Types, codes and the hex digit decoder shared by the parser modules.
// ----------------------------------------------------------------------------
package ihsp_pkg;

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_SKIP   = 3'd1,
    MODE_HEADER = 3'd2,
    MODE_EXT    = 3'd3,
    MODE_DATA   = 3'd4,
    MODE_HALT   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_GAP   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] REC_DATA     = 8'd0;
  localparam logic [7:0] REC_EXT_ADDR = 8'd4;
  localparam logic [7:0] FILL_BYTE    = 8'hFF;
  localparam int unsigned TDATA_W     = 72;

  typedef struct packed {
    logic       valid;
    logic [7:0] char_in;
  } char_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [31:0] position;
    logic [31:0] fill_count;
  } result_t;

  // Returns {digit_ok, nibble}.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// File: src/ihsp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HEX record parser input register
// Holds one accepted character word until the parser consumes it.
// ----------------------------------------------------------------------------
module ihsp_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 consume,
  output ihsp_pkg::char_word_t word
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] char_r;

  assign in_tready = !valid_r || consume;
  assign valid_nxt = (in_tvalid && in_tready) ? 1'b1 : (consume ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      char_r <= in_tdata;
    end
  end

  assign word.valid   = valid_r;
  assign word.char_in = char_r;

endmodule

// File: src/ihsp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HEX record parser core
// Line and record state machine; updates on each consumed character word.
// ----------------------------------------------------------------------------
module ihsp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [7:0]        char_in,
  output logic              res_valid,
  output ihsp_pkg::result_t res
);

  ihsp_pkg::mode_t mode_r, mode_nxt;
  logic [9:0]  char_index_r, char_index_nxt;
  logic [3:0]  first_nibble_r, first_nibble_nxt;
  logic [7:0]  record_length_r, record_length_nxt;
  logic [15:0] record_offset_r, record_offset_nxt;
  logic [15:0] upper_address_r, upper_address_nxt;
  logic [7:0]  upper_high_byte_r, upper_high_byte_nxt;
  logic [31:0] image_length_r, image_length_nxt;

  logic [4:0]  hx;
  logic [7:0]  byte_val;
  logic [8:0]  idx;
  logic [31:0] target;
  logic        emit;

  assign hx       = ihsp_pkg::hex_decode(char_in);
  assign byte_val = {first_nibble_r, hx[3:0]};
  assign idx      = char_index_r[9:1];
  assign target   = {upper_address_r, record_offset_r};

  always_comb begin
    mode_nxt            = mode_r;
    char_index_nxt      = char_index_r;
    first_nibble_nxt    = first_nibble_r;
    record_length_nxt   = record_length_r;
    record_offset_nxt   = record_offset_r;
    upper_address_nxt   = upper_address_r;
    upper_high_byte_nxt = upper_high_byte_r;
    image_length_nxt    = image_length_r;
    emit                = 1'b0;
    res.kind            = ihsp_pkg::KIND_DATA;
    res.data_byte       = 8'd0;
    res.position        = 32'd0;
    res.fill_count      = 32'd0;
    case (mode_r)
      ihsp_pkg::MODE_HALT: begin
      end
      ihsp_pkg::MODE_START: begin
        if (char_in == ihsp_pkg::CHAR_COLON) begin
          mode_nxt       = ihsp_pkg::MODE_HEADER;
          char_index_nxt = 10'd0;
        end else if (char_in != ihsp_pkg::CHAR_NEWLINE) begin
          mode_nxt = ihsp_pkg::MODE_SKIP;
        end
      end
      ihsp_pkg::MODE_SKIP: begin
        if (char_in == ihsp_pkg::CHAR_NEWLINE) begin
          mode_nxt = ihsp_pkg::MODE_START;
        end
      end
      ihsp_pkg::MODE_HEADER, ihsp_pkg::MODE_EXT, ihsp_pkg::MODE_DATA: begin
        if (!hx[4]) begin
          mode_nxt = ihsp_pkg::MODE_HALT;
          emit     = 1'b1;
          res.kind = ihsp_pkg::KIND_ERROR;
        end else if (!char_index_r[0]) begin
          first_nibble_nxt = hx[3:0];
          char_index_nxt   = char_index_r + 10'd1;
        end else begin
          char_index_nxt = char_index_r + 10'd1;
          if (mode_r == ihsp_pkg::MODE_HEADER) begin
            if (idx == 9'd0) begin
              record_length_nxt = byte_val;
            end else if (idx == 9'd1) begin
              record_offset_nxt = {byte_val, 8'd0};
            end else if (idx == 9'd2) begin
              record_offset_nxt = {record_offset_r[15:8], byte_val};
            end else begin
              char_index_nxt = 10'd0;
              if (byte_val == ihsp_pkg::REC_EXT_ADDR) begin
                mode_nxt = ihsp_pkg::MODE_EXT;
              end else if (byte_val == ihsp_pkg::REC_DATA) begin
                mode_nxt = (record_length_r == 8'd0) ? ihsp_pkg::MODE_SKIP
                                                     : ihsp_pkg::MODE_DATA;
                if (target > image_length_r) begin
                  emit             = 1'b1;
                  res.kind         = ihsp_pkg::KIND_GAP;
                  res.data_byte    = ihsp_pkg::FILL_BYTE;
                  res.position     = image_length_r;
                  res.fill_count   = target - image_length_r;
                  image_length_nxt = target;
                end
              end else begin
                mode_nxt = ihsp_pkg::MODE_SKIP;
              end
            end
          end else if (mode_r == ihsp_pkg::MODE_EXT) begin
            if (idx == 9'd0) begin
              upper_high_byte_nxt = byte_val;
            end else begin
              upper_address_nxt = {upper_high_byte_r, byte_val};
              mode_nxt          = ihsp_pkg::MODE_SKIP;
            end
          end else begin
            emit             = 1'b1;
            res.data_byte    = byte_val;
            res.position     = image_length_r;
            image_length_nxt = image_length_r + 32'd1;
            if (({1'b0, idx} + 10'd1) >= {2'b00, record_length_r}) begin
              mode_nxt = ihsp_pkg::MODE_SKIP;
            end
          end
        end
      end
      default: begin
        mode_nxt = ihsp_pkg::MODE_HALT;
      end
    endcase
  end

  assign res_valid = go && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r            <= ihsp_pkg::MODE_START;
      char_index_r      <= 10'd0;
      first_nibble_r    <= 4'd0;
      record_length_r   <= 8'd0;
      record_offset_r   <= 16'd0;
      upper_address_r   <= 16'd0;
      upper_high_byte_r <= 8'd0;
      image_length_r    <= 32'd0;
    end else if (go) begin
      mode_r            <= mode_nxt;
      char_index_r      <= char_index_nxt;
      first_nibble_r    <= first_nibble_nxt;
      record_length_r   <= record_length_nxt;
      record_offset_r   <= record_offset_nxt;
      upper_address_r   <= upper_address_nxt;
      upper_high_byte_r <= upper_high_byte_nxt;
      image_length_r    <= image_length_nxt;
    end
  end

endmodule

// File: src/ihsp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HEX record parser output register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module ihsp_out_stage (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  ihsp_pkg::result_t                     res,
  output logic                                  free,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ihsp_pkg::TDATA_W-1:0]          out_tdata,
  output logic [1:0]                            out_tuser
);

  logic              valid_r;
  logic              valid_nxt;
  ihsp_pkg::result_t res_r;

  assign free      = !valid_r || out_tready;
  assign valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.fill_count, res_r.position, res_r.data_byte};
  assign out_tuser  = res_r.kind;

endmodule

// File: src/intel_hex_stream_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HEX record stream parser, top level
// Parses a HEX text stream one character per word into a flat byte image.
//
//   Channel   Direction  Payload
//   in_*      slave      tdata[7:0] char_in
//   out_*     master     tdata data_byte, position, fill_count; tuser kind
//
// One character word is taken per cycle while the output is not stalled; a
// character passes the input register, and its result word the result register,
// before the result is valid at the port.
// Reset returns the parser to the start of a line with an empty image.
// A stalled output register holds the input register, which then holds
// in_tready low; every character waits then, also one that yields no result.
// ----------------------------------------------------------------------------
module intel_hex_stream_parser_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] char_in
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ihsp_pkg::TDATA_W-1:0] out_tdata,  // [7:0] data_byte, [39:8] position,
                                                   // [71:40] fill_count
  output logic [1:0]                   out_tuser   // [1:0] kind
);

  ihsp_pkg::char_word_t word;
  ihsp_pkg::result_t    res;
  logic                 res_valid;
  logic                 out_free;
  logic                 go;

  assign go = word.valid && out_free;

  ihsp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .consume   (go),
    .word      (word)
  );

  ihsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .char_in   (word.char_in),
    .res_valid (res_valid),
    .res       (res)
  );

  ihsp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_valid),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: src/ihsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HEX record parser port checker
// Checks result word consistency and output stall behavior at the ports.
// ----------------------------------------------------------------------------
`include "intel_hex_stream_parser_top_macros.svh"

module ihsp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [ihsp_pkg::TDATA_W-1:0] out_tdata,
  input logic [1:0]                   out_tuser
);

  `IHSP_ASSERT_IMPLY(a_kind_legal, clk, rst_n, out_tvalid, out_tuser != 2'd3)
  `IHSP_ASSERT_IMPLY(a_error_zero, clk, rst_n, out_tvalid && out_tuser == ihsp_pkg::KIND_ERROR, out_tdata == '0)
  `IHSP_ASSERT_IMPLY(a_gap_fields, clk, rst_n, out_tvalid && out_tuser == ihsp_pkg::KIND_GAP, out_tdata[71:40] != 32'd0 && out_tdata[7:0] == ihsp_pkg::FILL_BYTE)
  `IHSP_ASSERT_IMPLY(a_data_no_fill, clk, rst_n, out_tvalid && out_tuser == ihsp_pkg::KIND_DATA, out_tdata[71:40] == 32'd0)
  `IHSP_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

endmodule

bind intel_hex_stream_parser_top ihsp_checker u_ihsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
